>>> src/stbs_pkg.sv
// Shared constants and controller/datapath interface types for the sorted table search block.
package stbs_pkg;

   // Default sizes of the key table
   localparam int DEF_MAX_ENTRIES = 256;
   localparam int DEF_KEY_WIDTH   = 16;

   // Fixed field widths of the transaction payloads
   localparam int IDX_W    = 8;
   localparam int KEY_IN_W = 16;
   localparam int CSR_W    = 9;
   localparam int REQ_DATA_W = IDX_W + KEY_IN_W;
   localparam int RSP_DATA_W = IDX_W;

   // Request kinds carried on req_tuser
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Lookup status carried on rsp_tuser
   localparam logic STATUS_FOUND     = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write;      // store the request key into the table
      logic start;      // latch the lookup key and open the full window
      logic step;       // take the compare outcome of the current probe
      logic resp_load;  // load the output register with the result
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic window_empty;  // no entries left to probe
      logic key_hit;       // probed entry equals the lookup key
      logic rsp_free;      // output register can take a new result
   } dp_status_type;

endpackage

>>> src/sorted_table_binary_search.sv
// Top level of the sorted key table with binary search lookup.
//
// The block keeps a table of MAX_ENTRIES keys of KEY_WIDTH bits, filled by write
// transactions (req_tuser = 0) at entry_index, and meant to be kept in ascending
// order by the user. The number of entries searched comes from the csr write
// channel, saturated at MAX_ENTRIES; write it only while the block is idle. A lookup
// transaction (req_tuser = 1) runs a binary search over entries 0 to count-1 with a
// floor midpoint and unsigned compares, and returns one response transaction: status
// 0 and the index on a hit, status 1 and index 0 on a miss. Writes return nothing.
// A lookup reads the table RAM (registered read) and compares once per probe
// before the next address is known: the controller accepts the lookup, then reads
// and compares each probe in turn, closes an empty window on a miss, and loads the
// output register. No new request is taken while a lookup runs. A waiting response
// does not block the next request, but a second
// lookup result waits until the first one has been taken. Entries that were never
// written read back undefined.
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Entry count register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_W-1:0]      csr_data,    // entry_count
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] entry_index, [23:8] key_value
   input  logic                  req_tuser,   // req_type
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] match_index
   output logic                  rsp_tuser    // lookup_status
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // Take register writes at any time; the entry count register holds them from the next cycle
   assign csr_ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   stbs_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> src/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/stbs_ctrl.sv
// Controller state machine sequencing table writes and binary search probes.
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,
   output logic          req_tready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Read address is the window midpoint; stop once the window is empty
            state_in = sts.window_empty ? ST_RESP : ST_CMP;
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            state_in = sts.key_hit ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/stbs_datapath.sv
// Datapath: key table, search window, entry count register and output register.
module stbs_datapath
   import stbs_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_W-1:0]      csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         sts
);

   localparam int AW     = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int KEXT_W = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
   localparam int IEXT_W = (AW > IDX_W) ? AW : IDX_W;
   localparam int CEXT_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [IDX_W-1:0]     req_index;
   logic [KEXT_W-1:0]    key_ext;
   logic [KEY_WIDTH-1:0] req_key;
   logic [IEXT_W-1:0]    wr_index_ext;
   logic                 wr_in_range;
   logic [CEXT_W-1:0]    csr_ext;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;       // exclusive upper end of the window
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;

   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid;
   logic [IEXT_W-1:0]    mid_ext;
   logic [KEY_WIDTH-1:0] probe_key;

   assign req_index    = req_tdata[IDX_W-1:0];
   assign key_ext      = KEXT_W'(req_tdata[REQ_DATA_W-1:IDX_W]);
   assign req_key      = key_ext[KEY_WIDTH-1:0];
   assign wr_index_ext = IEXT_W'(req_index);
   assign wr_in_range  = (32'(req_index) < 32'(MAX_ENTRIES));
   assign csr_ext      = CEXT_W'(csr_data);

   // Floor midpoint of the inclusive window lo .. hi-1
   assign mid_sum = (CNT_W + 1)'(lo_ff) + (CNT_W + 1)'(hi_ff) - (CNT_W + 1)'(1);
   assign mid     = mid_sum[CNT_W:1];
   assign mid_ext = IEXT_W'(mid);

   stbs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write && wr_in_range),
      .wr_addr (wr_index_ext[AW-1:0]),
      .wr_data (req_key),
      .rd_addr (mid[AW-1:0]),
      .rd_data (probe_key)
   );

   assign sts.window_empty = (lo_ff >= hi_ff);
   assign sts.key_hit      = (probe_key == key_ff);
   assign sts.rsp_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      count_in      = count_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;

      // Saturate the entry count at the table size
      if (csr_valid) begin
         if (32'(csr_data) > 32'(MAX_ENTRIES)) begin
            count_in = CNT_W'(MAX_ENTRIES);
         end else begin
            count_in = csr_ext[CNT_W-1:0];
         end
      end

      if (cmd.start) begin
         key_in   = req_key;
         lo_in    = '0;
         hi_in    = count_ff;
         found_in = 1'b0;
      end

      if (cmd.step) begin
         if (probe_key == key_ff) begin
            found_in = 1'b1;
         end else if (key_ff < probe_key) begin
            hi_in = mid;
         end else begin
            lo_in = mid + CNT_W'(1);
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.resp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = found_ff ? STATUS_FOUND : STATUS_NOT_FOUND;
         rsp_index_in  = found_ff ? mid_ext[IDX_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> src/stbs_checker.sv
// Port-level checker for the sorted table search block and its bind.
module stbs_checker
   import stbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed or dropped");

   // A miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_NOT_FOUND) |-> rsp_tdata == '0)
      else $error("miss response with nonzero index");

   // A write transaction creates no response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_WRITE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after a write transaction");

   // Drop ready while a lookup is searching
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_LOOKUP) |=> !req_tready)
      else $error("request taken during a search");

   // No response straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/sorted_table_binary_search_test.sv
// Self-checking testbench for the sorted key table with binary search lookup.
`timescale 1ns / 1ps

module sorted_table_binary_search_test
   import stbs_pkg::*;
();

   localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
   localparam int DRAIN_CYCLES = 30;       // covers the longest lookup, output load included
   localparam int CYCLE_LIMIT  = 400000;   // many times the slowest legal run
   localparam int MAX_REPORTS  = 10;

   // One lookup response: status and matching position
   typedef struct packed {
      logic            status;
      logic [IDX_W-1:0] index;
   } lookup_outcome_type;

   // Shadow of the key table and entry count; predicts every lookup in order
   class lookup_scoreboard;
      logic [KEY_IN_W-1:0] key_store [TABLE_DEPTH];
      int unsigned         entry_limit;
      lookup_outcome_type  outcome_q [$];
      int unsigned         writes, lookups, hits, misses, mismatches;

      function new();
         foreach (key_store[i]) key_store[i] = '0;
         entry_limit = 0;
         writes      = 0;
         lookups     = 0;
         hits        = 0;
         misses      = 0;
         mismatches  = 0;
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      // Saturate the register value at the table depth
      function void set_count(logic [CSR_W-1:0] value);
         entry_limit = (int'(value) > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
      endfunction

      // Floor midpoint, unsigned compare, stop on the first equal probe
      function lookup_outcome_type search_keys(logic [KEY_IN_W-1:0] key);
         lookup_outcome_type r;
         int lo, hi, mid;
         r.status = STATUS_NOT_FOUND;
         r.index  = '0;
         lo = 0;
         hi = int'(entry_limit) - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < key_store[mid]) begin
               hi = mid - 1;
            end else if (key == key_store[mid]) begin
               r.status = STATUS_FOUND;
               r.index  = 8'(mid);
               return r;
            end else begin
               lo = mid + 1;
            end
         end
         return r;
      endfunction

      // Apply one accepted request transaction
      function void note_request(logic kind, logic [IDX_W-1:0] idx, logic [KEY_IN_W-1:0] key);
         lookup_outcome_type r;
         if (kind == REQ_WRITE) begin
            key_store[idx] = key;
            writes++;
         end else begin
            r = search_keys(key);
            outcome_q.push_back(r);
            lookups++;
            if (r.status == STATUS_FOUND) hits++;
            else misses++;
         end
      endfunction

      // Compare one accepted response transaction with the oldest prediction
      function void check_result(logic status, logic [RSP_DATA_W-1:0] index);
         lookup_outcome_type want;
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected response: status %0d index %0d",
                        $realtime, status, index);
            return;
         end
         want = outcome_q.pop_front();
         if (want.status !== status || want.index !== index) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"[%0t] response mismatch: expected status %0d index %0d, ",
                         "got status %0d index %0d"},
                        $realtime, want.status, want.index, status, index);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] entry_index, [23:8] key_value
   logic                  req_tuser  = 1'b0; // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [7:0] match_index
   logic                  rsp_tuser;         // lookup_status

   lookup_scoreboard board = new();

   int unsigned cycle_count  = 0;
   int unsigned count_writes = 0;
   int unsigned burst_left   = 4;
   bit          req_up       = 1'b0;
   logic [31:0] ready_pattern = '1;
   int unsigned pattern_age  = 0;

   sorted_table_binary_search dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Receiver: rotate a stall pattern, reload it when its age counter wraps
   always @(posedge clock) begin
      if (pattern_age == 63) begin
         case ($urandom_range(3))
            0: ready_pattern <= '1;
            1: ready_pattern <= $urandom | 32'h1;
            2: ready_pattern <= ($urandom & $urandom) | 32'h1;
            default: ready_pattern <= ($urandom | $urandom) | 32'h1;
         endcase
         pattern_age <= 0;
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
         pattern_age   <= pattern_age + 1;
      end
      rsp_tready <= ready_pattern[0];
   end

   // Check every accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser, rsp_tdata);
   end

   // Drop the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, board.pending());
      $display("FAIL sorted_table_binary_search");
      $finish;
   end

   // Send one request transaction; hold valid through bursts, idle between them
   task automatic send_req(logic kind, logic [IDX_W-1:0] idx, logic [KEY_IN_W-1:0] key);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {key, idx};
      req_up = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, idx, key);
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 15)
                                               : $urandom_range(6, 1);
      end
   endtask

   // Let the block go idle: drain all responses, then cover a trailing write
   task automatic settle();
      if (req_up) begin
         req_tvalid <= 1'b0;
         req_up = 1'b0;
      end
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_count(value);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   // One random transaction; scramble breaks the ascending order on writes
   task automatic random_item(bit scramble);
      int unsigned         roll, pick, slot, eff;
      logic [KEY_IN_W-1:0] key, lo_key, hi_key;
      roll = $urandom_range(99);
      eff  = board.entry_limit;
      if (roll < 20 || eff == 0) begin
         slot = $urandom_range(TABLE_DEPTH - 1);
         if (scramble) begin
            key = KEY_IN_W'($urandom);
         end else begin
            // keep the table sorted: stay between the neighbors
            lo_key = (slot == 0) ? '0 : board.key_store[slot - 1];
            hi_key = (slot == TABLE_DEPTH - 1) ? '1 : board.key_store[slot + 1];
            key = KEY_IN_W'($urandom_range(hi_key, lo_key));
         end
         send_req(REQ_WRITE, 8'(slot), key);
      end else begin
         pick = $urandom_range(99);
         slot = $urandom_range(eff - 1);
         if (pick < 50)      key = board.key_store[slot];
         else if (pick < 60) key = board.key_store[slot] + 16'd1;
         else if (pick < 70) key = board.key_store[slot] - 16'd1;
         else if (pick < 85) key = KEY_IN_W'($urandom);
         else                key = board.key_store[$urandom_range(TABLE_DEPTH - 1)];
         send_req(REQ_LOOKUP, 8'($urandom), key);
      end
   endtask

   initial begin
      int                  k, p, n, acc;
      logic [CSR_W-1:0]    count_val;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table after reset: no probe, always a miss
      send_req(REQ_LOOKUP, 8'hFF, 16'h0000);
      send_req(REQ_LOOKUP, 8'h00, 16'hFFFF);

      // Fill every entry with ascending keys, extremes at both ends
      acc = 0;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         if (k == TABLE_DEPTH - 1) acc = 16'hFFFF;
         else if (k > 0) acc = acc + $urandom_range(500);
         if (acc > 16'hFFFF) acc = 16'hFFFF;
         send_req(REQ_WRITE, 8'(k), 16'(acc));
      end

      // Full table: ends, first probes, near misses
      settle();
      write_count(9'd256);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[0]);
      send_req(REQ_LOOKUP, 8'hFF, board.key_store[255]);
      send_req(REQ_LOOKUP, 8'h5A, board.key_store[127]);
      send_req(REQ_LOOKUP, 8'hA5, board.key_store[128]);
      send_req(REQ_LOOKUP, 8'h01, board.key_store[1]);
      send_req(REQ_LOOKUP, 8'h80, board.key_store[200] + 16'd1);
      send_req(REQ_LOOKUP, 8'h7F, 16'h0000);

      // Count above the table depth saturates
      settle();
      write_count(9'h1FF);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[255]);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[3]);
      send_req(REQ_LOOKUP, 8'h00, 16'h8000);

      // Single entry
      settle();
      write_count(9'd1);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[0]);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[1]);
      send_req(REQ_LOOKUP, 8'h00, 16'hFFFF);

      // Explicit zero count
      settle();
      write_count(9'd0);
      send_req(REQ_LOOKUP, 8'h00, board.key_store[0]);

      // Random phases; the last two break the ascending order
      for (p = 0; p < 7; p++) begin
         settle();
         case (p)
            0: count_val = 9'd2;
            1: count_val = 9'd256;
            2: count_val = 9'($urandom_range(255, 3));
            3: count_val = 9'h1FF;
            4: count_val = 9'($urandom_range(200, 64));
            5: count_val = 9'($urandom_range(255, 3));
            default: count_val = 9'd256;
         endcase
         write_count(count_val);
         for (n = 0; n < 40; n++) random_item(p >= 5);
      end

      settle();
      $display("Covered %0d table writes and %0d lookups (%0d hits, %0d misses)",
               board.writes, board.lookups, board.hits, board.misses);
      $display("over %0d entry_count settings; mismatches: %0d, outstanding: %0d",
               count_writes, board.mismatches, board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS sorted_table_binary_search");
      end else begin
         $display("FAIL sorted_table_binary_search");
      end
      $finish;
   end

endmodule
